FILE: rtl/online_softmax_accumulator_top_defines.svh
// Assertion macros for the online softmax accumulator.
// Included by the top level only; depends on nothing else.
`ifndef ONLINE_SOFTMAX_ACCUMULATOR_TOP_DEFINES_SVH
`define ONLINE_SOFTMAX_ACCUMULATOR_TOP_DEFINES_SVH

// Implication in the same cycle.
`define OSA_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define OSA_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/osa_pkg.sv
// Shared types and constants of the online softmax accumulator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package osa_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACC   = 2'd1,
    CMD_MERGE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    PH_EMPTY  = 2'd0,
    PH_DIRECT = 2'd1,
    PH_BLEND  = 2'd2
  } phase_t;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [16:0] EXP_C1    = 17'd43025;
  localparam logic [16:0] EXP_C2    = 17'd10257;
  localparam logic [47:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [7:0]  VLEN_RESET = 8'd128;
  localparam int          LEN_W     = 11;
  localparam int          DIV_STEPS = 32;

  typedef enum logic [4:0] {
    ST_NONE, ST_ACCEPT, ST_DECODE, ST_CLEAR, ST_LOAD, ST_MAX,
    ST_X1, ST_X2, ST_X3, ST_X4, ST_X5,
    ST_SC_LO, ST_SC_HI, ST_SC_FIN, ST_WRITE,
    ST_DIV_INIT, ST_DIV_STEP, ST_DIV_FIN, ST_PUBLISH
  } step_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CLEAR, S_LOAD, S_MAX,
    S_X1, S_X2, S_X3, S_X4, S_X5,
    S_SC_LO, S_SC_HI, S_SC_FIN, S_WRITE,
    S_DIV_INIT, S_DIV_STEP, S_DIV_FIN, S_DONE
  } state_t;

  typedef struct packed {
    step_t      step;
    logic [1:0] job;
    logic       sel_new;
    logic       err;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      in_range;
    logic      psum_zero;
    logic      el_zero;
    phase_t    phase;
    logic      sum_zero;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/osa_channels.sv
// Handshake channel interfaces of the online softmax accumulator:
// request input, result output and configuration write. No dependencies.
`default_nettype none

interface osa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] score;
  logic signed [63:0] element_value;
  logic [47:0]        partial_sum;
  logic [6:0]         element;
  modport source(output valid, cmd, score, element_value, partial_sum, element,
                 input ready);
  modport sink(input valid, cmd, score, element_value, partial_sum, element,
               output ready);
endinterface

interface osa_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [31:0] result_value;
  logic [6:0]         result_element;
  modport source(output valid, status, result_value, result_element, input ready);
  modport sink(input valid, status, result_value, result_element, output ready);
endinterface

interface osa_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] vector_length;
  modport source(output valid, vector_length, input ready);
  modport sink(input valid, vector_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/osa_ctrl.sv
// Controller state machine: sequences the datapath steps of one request.
// Depends on osa_pkg.
`default_nettype none

module osa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire osa_pkg::dp_status_t st,
  output osa_pkg::dp_cmd_t         cmd
);
  import osa_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] job_r, job_nxt;
  logic       sel_r, sel_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       err_r, err_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] last_job;

  // Element 0 of a blend also rescales the exponential sum.
  assign last_job  = st.el_zero ? 2'd3 : 2'd1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= '0;
      sel_r       <= 1'b0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '{step: ST_NONE, job: job_r, sel_new: sel_r, err: err_r};
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = ST_ACCEPT;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.step = ST_DECODE;
        err_nxt  = 1'b0;
        job_nxt  = 2'd0;
        sel_nxt  = 1'b0;
        if (st.cmd == CMD_CLEAR) begin
          state_nxt = S_CLEAR;
        end else if (!st.in_range) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (st.cmd == CMD_READ) begin
          if (st.phase == PH_EMPTY || st.sum_zero) begin
            err_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIV_INIT;
          end
        end else if (st.cmd == CMD_MERGE && st.psum_zero) begin
          state_nxt = S_DONE;
        end else if (st.el_zero) begin
          state_nxt = (st.phase == PH_EMPTY) ? S_LOAD : S_MAX;
        end else if (st.phase == PH_EMPTY) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = (st.phase == PH_DIRECT) ? S_LOAD : S_SC_LO;
        end
      end
      S_CLEAR: begin
        cmd.step  = ST_CLEAR;
        state_nxt = S_DONE;
      end
      S_LOAD: begin
        cmd.step  = ST_LOAD;
        state_nxt = S_DONE;
      end
      S_MAX: begin
        cmd.step  = ST_MAX;
        state_nxt = S_X1;
      end
      S_X1: begin
        cmd.step  = ST_X1;
        state_nxt = S_X2;
      end
      S_X2: begin
        cmd.step  = ST_X2;
        state_nxt = S_X3;
      end
      S_X3: begin
        cmd.step  = ST_X3;
        state_nxt = S_X4;
      end
      S_X4: begin
        cmd.step  = ST_X4;
        state_nxt = S_X5;
      end
      S_X5: begin
        cmd.step = ST_X5;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_X1;
        end else begin
          state_nxt = S_SC_LO;
        end
      end
      S_SC_LO: begin
        cmd.step  = ST_SC_LO;
        state_nxt = S_SC_HI;
      end
      S_SC_HI: begin
        cmd.step  = ST_SC_HI;
        state_nxt = S_SC_FIN;
      end
      S_SC_FIN: begin
        cmd.step = ST_SC_FIN;
        if (job_r == last_job) begin
          state_nxt = S_WRITE;
        end else begin
          job_nxt   = job_r + 2'd1;
          state_nxt = S_SC_LO;
        end
      end
      S_WRITE: begin
        cmd.step  = ST_WRITE;
        state_nxt = S_DONE;
      end
      S_DIV_INIT: begin
        cmd.step  = ST_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.step = ST_DIV_STEP;
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = S_DIV_FIN;
        end
      end
      S_DIV_FIN: begin
        cmd.step  = ST_DIV_FIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.step      = ST_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/osa_datapath.sv
// Datapath: request registers, running state, accumulator memory, the shared
// multiplier for exp and scaling, and the restoring divider. Depends on osa_pkg.
`default_nettype none

module osa_datapath #(
  parameter int VEC_DEPTH = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire osa_pkg::dp_cmd_t    cmd,
  output osa_pkg::dp_status_t      st,
  input  wire logic [1:0]          in_cmd,
  input  wire logic signed [31:0]  in_score,
  input  wire logic signed [63:0]  in_element_value,
  input  wire logic [47:0]         in_partial_sum,
  input  wire logic [6:0]          in_element,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_vector_length,
  output logic                     res_status,
  output logic signed [31:0]       res_value,
  output logic [6:0]               res_element
);
  import osa_pkg::*;

  localparam int IDX_W = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
  localparam logic [LEN_W-1:0] HD_LEN = LEN_W'(VEC_DEPTH);

  // Request registers.
  cmd_code_t          cmd_q_r;
  logic signed [31:0] score_q_r;
  logic signed [63:0] val_q_r;
  logic [47:0]        psum_q_r;
  logic [6:0]         el_q_r;

  // Running state.
  logic [7:0]         vl_r;
  logic signed [31:0] rm_r;
  logic [47:0]        sum_r;
  logic [16:0]        old_r, new_r;
  phase_t             phase_r;
  logic [VEC_DEPTH-1:0] valid_r;
  logic [63:0]        mem [VEC_DEPTH];
  logic signed [63:0] mem_q_r;

  // Working registers.
  logic signed [31:0] m_r;
  logic [31:0]        dold_r, dnew_r;
  logic [48:0]        prod_r, lo_r;
  logic [15:0]        f_r, sq_r, a1_r;
  logic [16:0]        n_r;
  logic signed [63:0] sres_r [4];
  logic [47:0]        rem_r;
  logic [31:0]        dl_r, q_r;
  logic               ovf_r, dneg_r;
  logic signed [31:0] rv_r;
  logic               res_status_r;
  logic signed [31:0] res_value_r;
  logic [6:0]         res_el_r;

  logic [IDX_W+6:0]   idx_ext;
  logic [IDX_W-1:0]   idx;
  logic [LEN_W-1:0]   vl_ext, alen;
  logic [47:0]        src;
  logic [63:0]        xs, mag, mres, sres_val;
  logic               x_neg;
  logic [16:0]        sc;
  logic [31:0]        mul_a;
  logic [16:0]        mul_b;
  logic [48:0]        mul_p;
  logic [16:0]        p_exp, e_val;
  logic [80:0]        full;
  logic signed [63:0] blend, bsum;
  logic [48:0]        s49;
  logic [47:0]        sum_w;
  logic signed [31:0] m_c;
  logic [32:0]        dold_c, dnew_c;
  logic [63:0]        div_u;
  logic [48:0]        r2, rdiff;
  logic               ge;
  logic               mem_we;
  logic [63:0]        mem_wd;

  assign idx_ext = {{IDX_W{1'b0}}, el_q_r};
  assign idx     = idx_ext[IDX_W-1:0];
  assign vl_ext  = {3'b000, vl_r};
  assign alen    = (vl_ext == '0) ? LEN_W'(1) : ((vl_ext > HD_LEN) ? HD_LEN : vl_ext);
  assign src     = (cmd_q_r == CMD_MERGE) ? psum_q_r : 48'(ONE_Q16);

  assign st.cmd       = cmd_q_r;
  assign st.in_range  = ({4'b0000, el_q_r} < alen);
  assign st.psum_zero = (psum_q_r == '0);
  assign st.el_zero   = (el_q_r == '0);
  assign st.phase     = phase_r;
  assign st.sum_zero  = (sum_r == '0);

  // Scaling job operands: store by old scale, value by new scale,
  // sum by old scale, source sum by new scale.
  always_comb begin
    case (cmd.job)
      2'd0:    xs = mem_q_r;
      2'd1:    xs = val_q_r;
      2'd2:    xs = {16'h0000, sum_r};
      default: xs = {16'h0000, src};
    endcase
  end
  assign x_neg = xs[63];
  assign mag   = x_neg ? 64'd0 - xs : xs;
  assign sc    = cmd.job[0] ? new_r : old_r;

  always_comb begin
    case (cmd.step)
      ST_X1: begin
        mul_a = cmd.sel_new ? dnew_r : dold_r;
        mul_b = LOG2E_Q16;
      end
      ST_X2: begin
        mul_a = {16'h0000, prod_r[31:16]};
        mul_b = {1'b0, prod_r[31:16]};
      end
      ST_X3: begin
        mul_a = {16'h0000, f_r};
        mul_b = EXP_C1;
      end
      ST_X4: begin
        mul_a = {16'h0000, sq_r};
        mul_b = EXP_C2;
      end
      ST_SC_LO: begin
        mul_a = mag[31:0];
        mul_b = sc;
      end
      ST_SC_HI: begin
        mul_a = mag[63:32];
        mul_b = sc;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = {17'd0, mul_a} * {32'd0, mul_b};

  assign p_exp = ONE_Q16 - {1'b0, a1_r} + {1'b0, prod_r[31:16]};
  assign e_val = (n_r > 17'd16) ? 17'd0 : (p_exp >> n_r[4:0]);

  assign full     = {prod_r, 32'h0} + {32'h0, lo_r};
  assign mres     = full[79:16];
  assign sres_val = x_neg ? 64'd0 - mres : mres;

  // Saturating signed add of the two scaled terms.
  assign bsum  = sres_r[0] + sres_r[1];
  assign blend = ((sres_r[0][63] == sres_r[1][63]) && (bsum[63] != sres_r[0][63])) ?
                 (sres_r[0][63] ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}}) : bsum;
  assign s49   = {1'b0, sres_r[2][47:0]} + {1'b0, sres_r[3][47:0]};
  assign sum_w = s49[48] ? SUM_MAX : s49[47:0];

  assign m_c    = (score_q_r > rm_r) ? score_q_r : rm_r;
  assign dold_c = {m_c[31], m_c} - {rm_r[31], rm_r};
  assign dnew_c = {m_c[31], m_c} - {score_q_r[31], score_q_r};

  assign div_u = mem_q_r[63] ? 64'd0 - mem_q_r : mem_q_r;
  assign r2    = {rem_r, dl_r[31]};
  assign ge    = (r2 >= {1'b0, sum_r});
  assign rdiff = r2 - {1'b0, sum_r};

  assign mem_we = (cmd.step == ST_LOAD) || (cmd.step == ST_WRITE);
  assign mem_wd = (cmd.step == ST_LOAD) ? val_q_r : blend;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= mem_wd;
    end
    if (cmd.step == ST_DECODE) begin
      mem_q_r <= valid_r[idx] ? mem[idx] : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r    <= VLEN_RESET;
      rm_r    <= '0;
      sum_r   <= '0;
      old_r   <= '0;
      new_r   <= '0;
      phase_r <= PH_EMPTY;
      valid_r <= '0;
    end else begin
      if (cfg_we) begin
        vl_r <= cfg_vector_length;
      end
      case (cmd.step)
        ST_CLEAR: begin
          rm_r    <= '0;
          sum_r   <= '0;
          old_r   <= '0;
          new_r   <= '0;
          phase_r <= PH_EMPTY;
          valid_r <= '0;
        end
        ST_LOAD: begin
          valid_r[idx] <= 1'b1;
          if (phase_r == PH_EMPTY) begin
            rm_r    <= score_q_r;
            sum_r   <= src;
            phase_r <= PH_DIRECT;
          end
        end
        ST_X5: begin
          if (cmd.sel_new) begin
            new_r <= e_val;
          end else begin
            old_r <= e_val;
          end
        end
        ST_WRITE: begin
          valid_r[idx] <= 1'b1;
          if (el_q_r == '0) begin
            sum_r   <= sum_w;
            rm_r    <= m_r;
            phase_r <= PH_BLEND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (cmd.step)
      ST_ACCEPT: begin
        cmd_q_r   <= cmd_code_t'(in_cmd);
        score_q_r <= in_score;
        val_q_r   <= in_element_value;
        psum_q_r  <= in_partial_sum;
        el_q_r    <= in_element;
        rv_r      <= '0;
      end
      ST_MAX: begin
        m_r    <= m_c;
        dold_r <= dold_c[31:0];
        dnew_r <= dnew_c[31:0];
      end
      ST_X2: begin
        f_r <= prod_r[31:16];
        n_r <= prod_r[48:32];
      end
      ST_X3: sq_r <= prod_r[31:16];
      ST_X4: a1_r <= prod_r[31:16];
      ST_SC_HI: lo_r <= prod_r;
      ST_SC_FIN: sres_r[cmd.job] <= sres_val;
      ST_DIV_INIT: begin
        dneg_r <= mem_q_r[63];
        ovf_r  <= ({1'b0, div_u} >= {1'b0, sum_r, 16'h0000});
        rem_r  <= div_u[63:16];
        dl_r   <= {div_u[15:0], 16'h0000};
        q_r    <= '0;
      end
      ST_DIV_STEP: begin
        rem_r <= ge ? rdiff[47:0] : r2[47:0];
        dl_r  <= {dl_r[30:0], 1'b0};
        q_r   <= {q_r[30:0], ge};
      end
      ST_DIV_FIN: begin
        if (ovf_r || q_r[31]) begin
          rv_r <= dneg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          rv_r <= dneg_r ? 32'd0 - q_r : q_r;
        end
      end
      ST_PUBLISH: begin
        res_status_r <= cmd.err;
        res_value_r  <= rv_r;
        res_el_r     <= el_q_r;
      end
      default: begin
      end
    endcase
  end

  assign res_status  = res_status_r;
  assign res_value   = res_value_r;
  assign res_element = res_el_r;

endmodule

`default_nettype wire

FILE: rtl/online_softmax_accumulator_top.sv
// Top level of the online softmax accumulator: channels, controller, datapath.
// Depends on osa_pkg, osa_channels, osa_ctrl, osa_datapath and the defines header.
//
// Usage. Requests arrive on in_if (cmd, score, element_value, partial_sum,
// element); every request yields exactly one result on out_if (status,
// result_value, result_element). The vector length is written on cfg_if,
// which is always ready and must only be written while the block is idle.
// The block works on one request at a time. Errors and empty merges go from
// decode straight to the result; clear and direct loads pass through a clear
// or load step; a blended element scales the stored and the new value on the
// shared multiplier and writes back; element 0 of a blended token runs two exp
// evaluations and four scalings on one 32x17 multiplier; a read runs the 32-step
// restoring divider. Afterwards the block goes back to the accept state.
// The result sits in an output register, so a stalled receiver does not block
// the next request; only the following result waits until the slot is taken.
// Reset (rst_n low, synchronous) empties the state at once through per-entry
// valid bits, so no clearing pass is needed, and sets the vector length to 128.
`default_nettype none
`include "online_softmax_accumulator_top_defines.svh"

module online_softmax_accumulator_top #(
  parameter int VEC_DEPTH = 128
) (
  input wire logic clk,
  input wire logic rst_n,
  osa_in_if.sink   in_if,
  osa_out_if.source out_if,
  osa_cfg_if.sink  cfg_if
);
  import osa_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_st;

  // The vector length register takes a write in any cycle.
  assign cfg_if.ready = 1'b1;

  osa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .st        (dp_st),
    .cmd       (dp_cmd)
  );

  osa_datapath #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .st                (dp_st),
    .in_cmd            (in_if.cmd),
    .in_score          (in_if.score),
    .in_element_value  (in_if.element_value),
    .in_partial_sum    (in_if.partial_sum),
    .in_element        (in_if.element),
    .cfg_we            (cfg_if.valid),
    .cfg_vector_length (cfg_if.vector_length),
    .res_status        (out_if.status),
    .res_value         (out_if.result_value),
    .res_element       (out_if.result_element)
  );

  // A new result is only written into a free or departing output slot.
  `OSA_ASSERT_NOW(a_publish_slot_free, clk, rst_n, dp_cmd.step == ST_PUBLISH, !out_if.valid || out_if.ready, "result written over a waiting result")
  // Requests are taken only while the datapath is not busy.
  `OSA_ASSERT_NOW(a_ready_when_idle, clk, rst_n, in_if.ready, dp_cmd.step == ST_ACCEPT || dp_cmd.step == ST_NONE, "request taken while busy")
  // An accepted request is decoded in the next cycle.
  `OSA_ASSERT_NEXT(a_accept_decodes, clk, rst_n, in_if.valid && in_if.ready, dp_cmd.step == ST_DECODE, "accepted request not decoded")
  // A result appears only after a publish step.
  `OSA_ASSERT_NOW(a_valid_from_publish, clk, rst_n, $rose(out_if.valid), $past(dp_cmd.step == ST_PUBLISH), "result without publish")

endmodule

`default_nettype wire
